>>> sv/gbd_pkg.sv
// Shared types and constants for the grid breadth-first distance search.
// Holds field types, the queue entry and result layouts, and the neighbor step table.
// No dependencies.
package gbd_pkg;

  typedef logic [2:0] row_t;
  typedef logic [2:0] col_t;
  typedef logic [3:0] dist_t;
  typedef logic [3:0] dim_t;

  // Grid size in use, already saturated to the build limits
  typedef struct packed {
    dim_t rows;
    dim_t cols;
  } dims_t;

  // One queue entry: cell coordinates and its distance from the start
  typedef struct packed {
    row_t  row;
    col_t  col;
    dist_t steps;
  } entry_t;

  // One result item
  typedef struct packed {
    row_t  row;
    col_t  col;
    dist_t steps;
    logic  last;
    logic  invalid;
  } result_t;

  // Neighbor order: right, left, up, down
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // Row step per direction, two's complement
  function automatic logic [1:0] dir_dr(input logic [1:0] dir);
    logic [1:0] res;
    case (dir)
      DIR_UP:   res = 2'b11;
      DIR_DOWN: res = 2'b01;
      default:  res = 2'b00;
    endcase
    return res;
  endfunction

  // Column step per direction, two's complement
  function automatic logic [1:0] dir_dc(input logic [1:0] dir);
    logic [1:0] res;
    case (dir)
      DIR_RIGHT: res = 2'b01;
      DIR_LEFT:  res = 2'b11;
      default:   res = 2'b00;
    endcase
    return res;
  endfunction

endpackage

>>> sv/gbd_cfg.sv
// Configuration registers (grid rows and columns) behind a simple APB-style port.
// Produces the saturated grid size for the search engine. Uses gbd_pkg.
module gbd_cfg #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output gbd_pkg::dims_t       dims
);

  localparam logic ADDR_ROWS = 1'b0;
  localparam logic ADDR_COLS = 1'b1;
  localparam gbd_pkg::dim_t ROWS_CAP = gbd_pkg::dim_t'(MAX_ROWS);
  localparam gbd_pkg::dim_t COLS_CAP = gbd_pkg::dim_t'(MAX_COLS);

  gbd_pkg::dim_t rows_r, rows_nxt;
  gbd_pkg::dim_t cols_r, cols_nxt;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register write decode on the word address
  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (wr_en) begin
      case (paddr[2])
        ADDR_ROWS: rows_nxt = pwdata[3:0];
        ADDR_COLS: cols_nxt = pwdata[3:0];
        default:   rows_nxt = rows_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 4'd8;
      cols_r <= 4'd8;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  // Read back the stored values
  always_comb begin
    case (paddr[2])
      ADDR_ROWS: prdata = {28'd0, rows_r};
      ADDR_COLS: prdata = {28'd0, cols_r};
      default:   prdata = 32'd0;
    endcase
  end

  // Sizes above the build limits saturate
  assign dims.rows = (rows_r > ROWS_CAP) ? ROWS_CAP : rows_r;
  assign dims.cols = (cols_r > COLS_CAP) ? COLS_CAP : cols_r;

endmodule

>>> sv/gbd_queue_mem.sv
// Cell queue memory: one write port and one registered read port.
// Each entry holds a cell and its distance. Uses gbd_pkg.
module gbd_queue_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  gbd_pkg::entry_t   wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output gbd_pkg::entry_t   rdata
);

  gbd_pkg::entry_t mem [DEPTH];
  gbd_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/gbd_search.sv
// Search engine: sequencer for start, visited-map clear, dequeue, four neighbor probes and result.
// Owns the visited map memory and queue pointers, drives the queue memory. Uses gbd_pkg.
module gbd_search #(
  parameter int MAX_COLS = 8,
  parameter int CELLS    = 64,
  parameter int AW       = 6,
  parameter int PW       = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gbd_pkg::dims_t    dims,
  input  logic              in_valid,
  output logic              in_ready,
  input  gbd_pkg::row_t     start_row,
  input  gbd_pkg::col_t     start_col,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output gbd_pkg::entry_t   mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  gbd_pkg::entry_t   mem_rdata,
  output logic              out_valid,
  input  logic              out_ready,
  output gbd_pkg::result_t  out_res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INV  = 3'd1;
  localparam logic [2:0] S_CLR  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_NB   = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  localparam logic [PW-1:0] PTR_FULL = PW'(CELLS);
  localparam logic [AW-1:0] CLR_LAST = AW'(CELLS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [PW-1:0]     head_r, head_nxt;
  logic [PW-1:0]     tail_r, tail_nxt;
  logic [1:0]        dir_r, dir_nxt;
  logic              out_valid_r, out_valid_nxt;
  gbd_pkg::result_t  out_res_r, out_res_nxt;
  gbd_pkg::row_t     srow_r, srow_nxt;
  gbd_pkg::col_t     scol_r, scol_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic              chk_r, chk_nxt;
  logic              chk_in_r, chk_in_nxt;
  logic [AW-1:0]     chk_idx_r, chk_idx_nxt;
  gbd_pkg::row_t     chk_row_r, chk_row_nxt;
  gbd_pkg::col_t     chk_col_r, chk_col_nxt;

  // Visited map memory
  logic              vis_mem [CELLS];
  logic              vis_rd_r;
  logic              vis_we;
  logic [AW-1:0]     vis_waddr;
  logic              vis_wdata;
  logic              vis_re;
  logic [AW-1:0]     vis_raddr;

  logic              out_free;
  logic              start_bad;
  logic [AW-1:0]     start_idx;
  logic [1:0]        dr, dc;
  logic [4:0]        nrow, ncol;
  logic              nb_in;
  logic [AW-1:0]     nb_idx;
  logic              chk_take;
  logic [PW-1:0]     head_inc;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // Start cell checks
  assign start_bad = ({1'b0, start_row} >= dims.rows) || ({1'b0, start_col} >= dims.cols);
  assign start_idx = AW'(int'(srow_r) * MAX_COLS + int'(scol_r));

  // Neighbor of the dequeued cell in the current direction
  assign dr     = gbd_pkg::dir_dr(dir_r);
  assign dc     = gbd_pkg::dir_dc(dir_r);
  assign nrow   = {2'b00, mem_rdata.row} + {{3{dr[1]}}, dr};
  assign ncol   = {2'b00, mem_rdata.col} + {{3{dc[1]}}, dc};
  assign nb_in  = !nrow[4] && (nrow[3:0] < dims.rows) && !ncol[4] && (ncol[3:0] < dims.cols);
  assign nb_idx = AW'(int'(nrow[2:0]) * MAX_COLS + int'(ncol[2:0]));

  // Probe from the previous cycle: visited bit is now on the memory output
  assign chk_take = chk_r && chk_in_r && !vis_rd_r && (tail_r < PTR_FULL);
  assign head_inc = head_r + PW'(1);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    dir_nxt       = dir_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    srow_nxt      = srow_r;
    scol_nxt      = scol_r;
    clr_nxt       = clr_r;
    chk_nxt       = 1'b0;
    chk_in_nxt    = chk_in_r;
    chk_idx_nxt   = chk_idx_r;
    chk_row_nxt   = chk_row_r;
    chk_col_nxt   = chk_col_r;
    mem_we        = 1'b0;
    mem_waddr     = tail_r[AW-1:0];
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = head_r[AW-1:0];
    vis_we        = 1'b0;
    vis_waddr     = chk_idx_r;
    vis_wdata     = 1'b1;
    vis_re        = 1'b0;
    vis_raddr     = nb_idx;

    // Output register drains when taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Enqueue a neighbor not seen yet
    if (chk_take) begin
      mem_we          = 1'b1;
      mem_waddr       = tail_r[AW-1:0];
      mem_wdata.row   = chk_row_r;
      mem_wdata.col   = chk_col_r;
      mem_wdata.steps = mem_rdata.steps + 4'd1;
      vis_we          = 1'b1;
      vis_waddr       = chk_idx_r;
      vis_wdata       = 1'b1;
      tail_nxt        = tail_r + PW'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          srow_nxt    = start_row;
          scol_nxt    = start_col;
          head_nxt    = '0;
          tail_nxt    = '0;
          if (start_bad) begin
            state_nxt = S_INV;
          end else begin
            mem_we          = 1'b1;
            mem_waddr       = '0;
            mem_wdata.row   = start_row;
            mem_wdata.col   = start_col;
            mem_wdata.steps = '0;
            tail_nxt        = PW'(1);
            clr_nxt         = '0;
            state_nxt       = S_CLR;
          end
        end
      end
      S_INV: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_res_nxt.row     = srow_r;
          out_res_nxt.col     = scol_r;
          out_res_nxt.steps   = '0;
          out_res_nxt.last    = 1'b1;
          out_res_nxt.invalid = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      S_CLR: begin
        // Clear the visited map one entry per cycle, marking the start cell
        vis_we    = 1'b1;
        vis_waddr = clr_r;
        vis_wdata = (clr_r == start_idx);
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        mem_raddr = head_r[AW-1:0];
        dir_nxt   = gbd_pkg::DIR_RIGHT;
        state_nxt = S_NB;
      end
      S_NB: begin
        // Read the visited bit of one neighbor per cycle, checked next cycle
        vis_re      = 1'b1;
        vis_raddr   = nb_idx;
        chk_nxt     = 1'b1;
        chk_in_nxt  = nb_in;
        chk_idx_nxt = nb_idx;
        chk_row_nxt = nrow[2:0];
        chk_col_nxt = ncol[2:0];
        dir_nxt     = dir_r + 2'd1;
        if (dir_r == gbd_pkg::DIR_DOWN) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        // Last neighbor check happens in this cycle
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // Result for the dequeued cell, and fetch of the next one
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_res_nxt.row     = mem_rdata.row;
          out_res_nxt.col     = mem_rdata.col;
          out_res_nxt.steps   = mem_rdata.steps;
          out_res_nxt.last    = (head_inc == tail_r);
          out_res_nxt.invalid = 1'b0;
          head_nxt            = head_inc;
          mem_re              = 1'b1;
          mem_raddr           = head_inc[AW-1:0];
          dir_nxt             = gbd_pkg::DIR_RIGHT;
          state_nxt           = (head_inc == tail_r) ? S_IDLE : S_NB;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      dir_r       <= '0;
      out_valid_r <= 1'b0;
      clr_r       <= '0;
      chk_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
      clr_r       <= clr_nxt;
      chk_r       <= chk_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    srow_r    <= srow_nxt;
    scol_r    <= scol_nxt;
    chk_in_r  <= chk_in_nxt;
    chk_idx_r <= chk_idx_nxt;
    chk_row_r <= chk_row_nxt;
    chk_col_r <= chk_col_nxt;
  end

  // Visited map: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (vis_re) begin
      vis_rd_r <= vis_mem[vis_raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

>>> sv/grid_bfs_distance.sv
// Grid breadth-first distance search, 4-neighbor, open grid; top level.
// Valid start: visited-map clear of every entry, one fetch, then per cell four neighbor probes,
// one check and one result; the next item is taken once the result of the last cell is out.
// Outside start: an invalid result, then the next item is taken. A waiting result holds
// the search.
// Reset is synchronous, active low; the grid size returns to 8x8.
module grid_bfs_distance #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [2:0] start_row, [5:3] start_col
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [2:0] cell_row, [5:3] cell_col, [9:6] step_distance
  output logic        out_tlast,   // is_last
  output logic        out_tuser,   // [0] start_invalid
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int PW    = $clog2(CELLS + 1);

  gbd_pkg::dims_t   dims;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  gbd_pkg::entry_t  mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  gbd_pkg::entry_t  mem_rdata;
  gbd_pkg::result_t out_res;

  gbd_cfg #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .dims    (dims)
  );

  gbd_queue_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_queue (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  gbd_search #(
    .MAX_COLS (MAX_COLS),
    .CELLS    (CELLS),
    .AW       (AW),
    .PW       (PW)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .dims      (dims),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .start_row (in_tdata[2:0]),
    .start_col (in_tdata[5:3]),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Pack the result item
  assign out_tdata = {6'd0, out_res.steps, out_res.col, out_res.row};
  assign out_tlast = out_res.last;
  assign out_tuser = out_res.invalid;

endmodule

>>> verif/grid_bfs_distance_tb.sv
// Self-checking testbench for grid_bfs_distance: directed table, then random search phases.
// Expected cells come from an in-bench breadth-first predictor; both stream sides idle at random.
// Depends on gbd_pkg (field and result types, neighbor direction codes) and the RTL top level.
module grid_bfs_distance_tb;

  localparam int GRID_MAX = 8;
  localparam logic [2:0] REG_GRID_ROWS = 3'd0;
  localparam logic [2:0] REG_GRID_COLS = 3'd4;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 38;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 12;

  // How a directed row is checked
  typedef enum logic [1:0] {
    CHECK_PREDICTED,
    CHECK_OUT_OF_GRID,
    CHECK_SINGLE_CELL
  } check_kind_t;

  typedef struct packed {
    gbd_pkg::dim_t rows;
    gbd_pkg::dim_t cols;
    gbd_pkg::row_t sr;
    gbd_pkg::col_t sc;
    check_kind_t   kind;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [2:0] start_row, [5:3] start_col
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;   // [2:0] cell_row, [5:3] cell_col, [9:6] step_distance
  logic        out_tlast;   // is_last
  logic        out_tuser;   // [0] start_invalid
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predictor copy of the grid size registers
  gbd_pkg::dim_t grid_rows_cfg = 4'd8;
  gbd_pkg::dim_t grid_cols_cfg = 4'd8;

  gbd_pkg::result_t expected_cells [$];
  dir_row_t         directed_tab [$];
  int               mismatch_count = 0;
  int               hold_requests = 0;
  int               burst_left = 0;

  grid_bfs_distance dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit, far above the slowest correct run
  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

  // Dimension in use: oversized values clamp to the build limit
  function automatic int eff_dim(input gbd_pkg::dim_t v);
    return (v > GRID_MAX) ? GRID_MAX : int'(v);
  endfunction

  // Breadth-first search over the open grid; queues one expected cell per dequeue
  function automatic void predict_search(input gbd_pkg::row_t sr, input gbd_pkg::col_t sc);
    int               rows, cols, head, tail, cur, r, c, nr, nc, nb;
    bit               seen [GRID_MAX*GRID_MAX];
    int               fifo [GRID_MAX*GRID_MAX];
    int               dist_of [GRID_MAX*GRID_MAX];
    gbd_pkg::result_t res;
    gbd_pkg::result_t found [$];
    rows = eff_dim(grid_rows_cfg);
    cols = eff_dim(grid_cols_cfg);
    if (sr >= rows || sc >= cols) begin
      res.row = sr;
      res.col = sc;
      res.steps = '0;
      res.last = 1'b1;
      res.invalid = 1'b1;
      expected_cells.push_back(res);
      return;
    end
    foreach (seen[k]) seen[k] = 1'b0;
    head = 0;
    tail = 1;
    fifo[0] = sr * GRID_MAX + sc;
    dist_of[fifo[0]] = 0;
    seen[fifo[0]] = 1'b1;
    while (head < tail) begin
      cur = fifo[head];
      head++;
      r = cur / GRID_MAX;
      c = cur % GRID_MAX;
      res.row = gbd_pkg::row_t'(r);
      res.col = gbd_pkg::col_t'(c);
      res.steps = gbd_pkg::dist_t'(dist_of[cur]);
      res.last = 1'b0;
      res.invalid = 1'b0;
      found.push_back(res);
      // right, left, up, down
      for (int d = 0; d < 4; d++) begin
        nr = r + ((d == gbd_pkg::DIR_UP) ? -1 : (d == gbd_pkg::DIR_DOWN) ? 1 : 0);
        nc = c + ((d == gbd_pkg::DIR_LEFT) ? -1 : (d == gbd_pkg::DIR_RIGHT) ? 1 : 0);
        if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
        nb = nr * GRID_MAX + nc;
        if (!seen[nb]) begin
          seen[nb] = 1'b1;
          dist_of[nb] = dist_of[cur] + 1;
          fifo[tail] = nb;
          tail++;
        end
      end
    end
    res = found.pop_back();
    res.last = 1'b1;
    found.push_back(res);
    foreach (found[k]) expected_cells.push_back(found[k]);
  endfunction

  // Register write: setup then access; called and returns at a rising edge
  task automatic cfg_write(input logic [2:0] addr, input gbd_pkg::dim_t val);
    logic [31:0] wdata;
    wdata = $urandom();
    wdata[3:0] = val;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == REG_GRID_ROWS) grid_rows_cfg = val;
    else grid_cols_cfg = val;
  endtask

  // Drop valid and wait until every expected cell has been checked
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dims(input gbd_pkg::dim_t rows, input gbd_pkg::dim_t cols);
    wait_drained();
    cfg_write(REG_GRID_ROWS, rows);
    cfg_write(REG_GRID_COLS, cols);
  endtask

  // Offer one start item in bursts with random gaps; record its expectations on acceptance
  task automatic send_start(input gbd_pkg::row_t sr, input gbd_pkg::col_t sc,
                            input check_kind_t kind);
    int               gap;
    gbd_pkg::result_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, sc, sr};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    if (kind == CHECK_PREDICTED) begin
      predict_search(sr, sc);
    end else begin
      res.row = sr;
      res.col = sc;
      res.steps = '0;
      res.last = 1'b1;
      res.invalid = (kind == CHECK_OUT_OF_GRID);
      expected_cells.push_back(res);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    gbd_pkg::result_t got;
    gbd_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.row = out_tdata[2:0];
      got.col = out_tdata[5:3];
      got.steps = out_tdata[9:6];
      got.last = out_tlast;
      got.invalid = out_tuser;
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected item: expected none, got row %0d col %0d dist %0d",
                 $time, got.row, got.col, got.steps);
        mismatch_count++;
      end else begin
        want = expected_cells.pop_front();
        check_field("cell_row", want.row, got.row);
        check_field("cell_col", want.col, got.col);
        check_field("step_distance", want.steps, got.steps);
        check_field("is_last", want.last, got.last);
        check_field("start_invalid", want.invalid, got.invalid);
      end
    end
  end

  // Receiver: segments of always-ready, random, periodic and mostly-stalled behavior,
  // plus a long hold-off when the stimulus asks for one
  initial begin : receiver
    int mode;
    int seg_left;
    int hold_left;
    int hold_served;
    out_tready = 1'b0;
    mode = 0;
    seg_left = 0;
    hold_left = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        mode = $urandom_range(0, 3);
        seg_left = $urandom_range(1, 60);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 9) < 7);
          2:       out_tready <= (seg_left % 3 == 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    gbd_pkg::dim_t rows;
    gbd_pkg::dim_t cols;
    gbd_pkg::row_t sr;
    gbd_pkg::col_t sc;
    int            eff_r;
    int            eff_c;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;

    // Grid size, start cell, how the results are checked
    directed_tab = '{
      '{4'd8,  4'd8, 3'd0, 3'd0, CHECK_PREDICTED},    // reset size, corner start
      '{4'd8,  4'd8, 3'd7, 3'd7, CHECK_PREDICTED},
      '{4'd8,  4'd8, 3'd3, 3'd4, CHECK_PREDICTED},
      '{4'd15, 4'd15, 3'd7, 3'd0, CHECK_PREDICTED},   // oversized, clamps to 8x8
      '{4'd0,  4'd8, 3'd0, 3'd0, CHECK_OUT_OF_GRID},  // zero rows: empty grid
      '{4'd8,  4'd0, 3'd5, 3'd2, CHECK_OUT_OF_GRID},  // zero cols
      '{4'd0,  4'd0, 3'd7, 3'd7, CHECK_OUT_OF_GRID},
      '{4'd1,  4'd1, 3'd0, 3'd0, CHECK_SINGLE_CELL},
      '{4'd1,  4'd1, 3'd0, 3'd1, CHECK_OUT_OF_GRID},
      '{4'd1,  4'd1, 3'd1, 3'd0, CHECK_OUT_OF_GRID},
      '{4'd1,  4'd8, 3'd0, 3'd7, CHECK_PREDICTED},
      '{4'd8,  4'd1, 3'd7, 3'd0, CHECK_PREDICTED},
      '{4'd3,  4'd5, 3'd2, 3'd4, CHECK_PREDICTED},
      '{4'd3,  4'd5, 3'd3, 3'd4, CHECK_OUT_OF_GRID},  // row just past the edge
      '{4'd3,  4'd5, 3'd2, 3'd5, CHECK_OUT_OF_GRID},  // col just past the edge
      '{4'd3,  4'd5, 3'd7, 3'd7, CHECK_OUT_OF_GRID},
      '{4'd9,  4'd8, 3'd4, 3'd4, CHECK_PREDICTED},
      '{4'd15, 4'd1, 3'd7, 3'd0, CHECK_PREDICTED},
      '{4'd8,  4'd8, 3'd1, 3'd6, CHECK_PREDICTED}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_tab[k]) begin
      if (directed_tab[k].rows != grid_rows_cfg || directed_tab[k].cols != grid_cols_cfg)
        set_dims(directed_tab[k].rows, directed_tab[k].cols);
      send_start(directed_tab[k].sr, directed_tab[k].sc, directed_tab[k].kind);
    end

    // Random phases: each at its own grid size, extremes first
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0:       begin rows = 4'd8;  cols = 4'd8;  end
        1:       begin rows = 4'd1;  cols = 4'd1;  end
        2:       begin rows = 4'd15; cols = 4'd15; end
        3:       begin rows = 4'd0;  cols = 4'd5;  end
        4:       begin rows = 4'd1;  cols = 4'd8;  end
        5:       begin rows = 4'd8;  cols = 4'd1;  end
        6:       begin rows = 4'd7;  cols = 4'd0;  end
        default: begin
          rows = gbd_pkg::dim_t'($urandom_range(1, 8));
          cols = gbd_pkg::dim_t'($urandom_range(1, 8));
        end
      endcase
      set_dims(rows, cols);
      eff_r = eff_dim(rows);
      eff_c = eff_dim(cols);
      // Full-size grid with the receiver held off: the block must back up its input
      if (phase == 0) hold_requests++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && phase % 3 == 0) wait_drained();
        if (eff_r == 0 || eff_c == 0 || $urandom_range(0, 6) == 0) begin
          sr = gbd_pkg::row_t'($urandom_range(0, 7));
          sc = gbd_pkg::col_t'($urandom_range(0, 7));
        end else begin
          sr = gbd_pkg::row_t'($urandom_range(0, eff_r - 1));
          sc = gbd_pkg::col_t'($urandom_range(0, eff_c - 1));
        end
        send_start(sr, sc, CHECK_PREDICTED);
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> grid_bfs_distance.f
sv/gbd_pkg.sv
sv/gbd_cfg.sv
sv/gbd_queue_mem.sv
sv/gbd_search.sv
sv/grid_bfs_distance.sv
verif/grid_bfs_distance_tb.sv
